// File: design/wms_pkg.sv
// Shared constants and controller/datapath interface types for the window median block.
package wms_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 8;
    localparam int PIX_W           = 8;

    typedef struct packed {
        logic load;        // latch input word, start insertion
        logic drop;        // store full: mark overflow
        logic rd_prev;     // read entry below insertion point
        logic wr_shift;    // move read entry up one slot, step down
        logic wr_sample;   // place sample at insertion point
        logic rd_mid;      // read middle entry
        logic emit;        // load output register, clear window
    } wms_cmd_t;

    typedef struct packed {
        logic full;        // fill count at capacity
        logic pos_zero;    // insertion point at bottom of store
        logic greater;     // read entry above the new sample
        logic last;        // current sample closes the window
    } wms_sts_t;

endpackage

// File: design/window_median_select.sv
// Top level: window median selector built from a sequencer and a sorted-store datapath.
//
//   channel | ports                          | direction | carries
//   --------+--------------------------------+-----------+-------------------------------
//   input   | s_valid s_ready s_sample s_last | in        | one window sample per word
//   result  | m_valid m_ready m_median m_overflow | out   | median of a closed window
//
// Insertion: a sample that moves k stored entries up takes one store read
//   and one store write per entry, walking down from the top of the window;
//   a sample dropped at capacity only marks overflow.
//   A word marked last adds a middle-entry read.
// Reset: aresetn is synchronous, active low; it empties the window and
//   drops any pending result. Store contents are not cleared.
// Stalls: the result sits in an output register, so new samples are taken
//   while it waits; only a second median waits for m_ready.
module window_median_select #(
    parameter int MAX_WINDOW  = wms_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = wms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [wms_pkg::PIX_W-1:0]   s_sample,
    input  logic                        s_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [wms_pkg::PIX_W-1:0]   m_median,
    output logic                        m_overflow
);
    import wms_pkg::*;

    // command/status between sequencer and datapath
    wms_cmd_t cmd;
    wms_sts_t sts;

    wms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // sorted store holds the window in ascending order; the median is
    // the entry at index count/2 (upper middle for even windows)
    wms_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_sample   (s_sample),
        .s_last     (s_last),
        .cmd        (cmd),
        .sts        (sts),
        .m_median   (m_median),
        .m_overflow (m_overflow)
    );

endmodule

// File: design/wms_datapath.sv
// Sorted sample store, insertion pointer, fill count and result register.
module wms_datapath #(
    parameter int MAX_WINDOW  = wms_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = wms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [wms_pkg::PIX_W-1:0]   s_sample,
    input  logic                        s_last,
    input  wms_pkg::wms_cmd_t           cmd,
    output wms_pkg::wms_sts_t           sts,
    output logic [wms_pkg::PIX_W-1:0]   m_median,
    output logic                        m_overflow
);
    import wms_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [SAMPLE_BITS-1:0] store_mem [MAX_WINDOW];

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   last_reg;
    logic [CNT_W-1:0]       pos_reg;
    logic [CNT_W-1:0]       fill_count_reg;
    logic [CNT_W-1:0]       fill_count_next;
    logic                   dropped_reg;
    logic                   dropped_next;
    logic [SAMPLE_BITS-1:0] rdata_reg;
    logic [PIX_W-1:0]       median_reg;
    logic                   overflow_reg;

    logic [CNT_W-1:0]       pos_prev;
    logic [CNT_W-1:0]       mid;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic [SAMPLE_BITS-1:0] wr_data;

    assign pos_prev = pos_reg - CNT_W'(1);
    assign mid      = fill_count_reg >> 1;
    assign rd_addr  = cmd.rd_mid ? mid[ADDR_W-1:0] : pos_prev[ADDR_W-1:0];
    assign wr_addr  = pos_reg[ADDR_W-1:0];
    assign wr_data  = cmd.wr_shift ? rdata_reg : sample_reg;

    // store: one write port, one read port with registered data
    always_ff @(posedge aclk) begin
        if (cmd.wr_shift || cmd.wr_sample) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_prev || cmd.rd_mid) begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= SAMPLE_BITS'(s_sample);
            last_reg   <= s_last;
            pos_reg    <= fill_count_reg;
        end else if (cmd.wr_shift) begin
            pos_reg    <= pos_prev;
        end
        if (cmd.emit) begin
            median_reg   <= PIX_W'(rdata_reg);
            overflow_reg <= dropped_reg;
        end
    end

    always_comb begin
        fill_count_next = fill_count_reg;
        dropped_next    = dropped_reg;
        if (cmd.wr_sample) begin
            fill_count_next = fill_count_reg + CNT_W'(1);
        end
        if (cmd.drop) begin
            dropped_next = 1'b1;
        end
        if (cmd.emit) begin
            fill_count_next = '0;
            dropped_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            dropped_reg    <= 1'b0;
        end else begin
            fill_count_reg <= fill_count_next;
            dropped_reg    <= dropped_next;
        end
    end

    assign sts.full     = (fill_count_reg == CNT_W'(MAX_WINDOW));
    assign sts.pos_zero = (pos_reg == '0);
    assign sts.greater  = (rdata_reg > sample_reg);
    assign sts.last     = last_reg;

    assign m_median   = median_reg;
    assign m_overflow = overflow_reg;

endmodule

// File: design/wms_ctrl.sv
// Sequencer for insertion, median read and result handshake.
module wms_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  wms_pkg::wms_sts_t   sts,
    output wms_pkg::wms_cmd_t   cmd
);
    import wms_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHK  = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_MED  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (sts.full) begin
                    cmd.drop   = 1'b1;
                    state_next = ST_FIN;
                end else if (sts.pos_zero) begin
                    cmd.wr_sample = 1'b1;
                    state_next    = ST_FIN;
                end else begin
                    cmd.rd_prev = 1'b1;
                    state_next  = ST_CMP;
                end
            end
            ST_CMP: begin
                if (sts.greater) begin
                    cmd.wr_shift = 1'b1;
                    state_next   = ST_CHK;
                end else begin
                    cmd.wr_sample = 1'b1;
                    state_next    = ST_FIN;
                end
            end
            ST_FIN: begin
                if (sts.last) begin
                    cmd.rd_mid = 1'b1;
                    state_next = ST_MED;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MED: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
